FILE: rtl/lcgrd_pkg.sv
// lcgrd_pkg: shared constants for the LCG range draw unit and its checker.
// No dependencies.
`default_nettype none

package lcgrd_pkg;

    localparam int DEF_VALUE_WIDTH = 16;

    // residue, multiplier, increment, modulus and seed width
    localparam int RES_W = 31;

    // configuration register indices
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MULT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INCR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GLEN = 3'd5;

    // reset values
    localparam logic [RES_W-1:0] RST_MULT = 31'd1103515245;
    localparam logic [RES_W-1:0] RST_INCR = 31'd12345;
    localparam logic [RES_W-1:0] RST_MOD  = 31'd2147483647;
    localparam logic [RES_W-1:0] RST_SEED = 31'd1;
    localparam int               RST_TOP  = 6;
    localparam int               RST_GLEN = 10;

endpackage

`default_nettype wire

FILE: rtl/lcg_range_draw_with_spread_unit.sv
// lcg_range_draw_with_spread_unit: LCG draw generator with group spread tracking.
// Depends on lcgrd_pkg.
//
// Channel   Direction  Signals
// tick      in         i_tick_valid / o_tick_ready, i_tick
// result    out        o_res_valid / i_res_ready, o_draw_value, o_spread, o_group_end
// config    in         i_cfg_we, i_cfg_idx, i_cfg_data (no handshake)
//
// A request with tick one makes two passes through one multiplier and one
// restoring divider that retires a quotient bit per cycle, first for the
// modulo, then for the range scaling.
// A request with tick zero is taken and does nothing.
// Reset is synchronous, active low; the first request can be taken right after it.
// A finished result waits in the output register; a new request is taken while
// it waits, and the unit stalls only when the next result finds it still full.
`default_nettype none

module lcg_range_draw_with_spread_unit #(
    parameter int VALUE_WIDTH = lcgrd_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [lcgrd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [((VALUE_WIDTH > lcgrd_pkg::RES_W) ?
                   VALUE_WIDTH : lcgrd_pkg::RES_W)-1:0] i_cfg_data,
    input  logic                                   i_tick_valid,
    output logic                                   o_tick_ready,
    input  logic                                   i_tick,
    output logic                                   o_res_valid,
    input  logic                                   i_res_ready,
    output logic [VALUE_WIDTH-1:0]                 o_draw_value,
    output logic [VALUE_WIDTH-1:0]                 o_spread,
    output logic                                   o_group_end
);
    import lcgrd_pkg::*;

    localparam int MulBW = (VALUE_WIDTH > RES_W) ? VALUE_WIDTH : RES_W;
    localparam int ProdW = RES_W + MulBW;
    localparam int DivW  = ProdW + 1;
    localparam int CntW  = $clog2(DivW);

    typedef logic [MulBW-1:0]       t_mulb;
    typedef logic [ProdW-1:0]       t_prod;
    typedef logic [DivW-1:0]        t_div;
    typedef logic [VALUE_WIDTH-1:0] t_val;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_STEP = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // configuration registers
    logic [RES_W-1:0] r_mult, r_incr, r_mod, r_seed;
    t_val             r_top, r_glen;

    // sequencer and datapath
    logic [2:0]       r_state;
    logic             r_phase;      // 0: modulo pass, 1: scaling pass
    logic [CntW-1:0]  r_cnt;
    t_prod            r_prod;
    t_div             r_div;
    logic [RES_W-1:0] r_rem;
    logic [RES_W-1:0] r_residue;
    t_val             r_min, r_max, r_count;

    // result register
    logic             r_res_valid;
    t_val             r_draw, r_spread;
    logic             r_group_end;

    logic [RES_W:0]   eff_mod;
    t_val             eff_top;
    t_mulb            mul_b;
    logic [RES_W:0]   trial;
    logic             ge;
    logic [RES_W-1:0] n_rem;
    t_div             n_div;
    t_val             n_draw, n_max, n_min, n_count;
    logic             last;
    logic             out_free;
    logic             cfg_hit;
    logic [RES_W-1:0] n_seed;
    t_val             n_top;

    assign eff_mod = (r_mod == '0) ? {1'b1, {RES_W{1'b0}}} : {1'b0, r_mod};
    assign eff_top = (r_top == '0) ? t_val'(1) : r_top;
    assign mul_b   = r_phase ? t_mulb'(eff_top) : t_mulb'(r_mult);

    // restoring division step, one quotient bit per cycle
    assign trial = {r_rem, r_div[DivW-1]};
    assign ge    = (trial >= eff_mod);
    assign n_rem = ge ? RES_W'(trial - eff_mod) : trial[RES_W-1:0];
    assign n_div = {r_div[DivW-2:0], ge};

    // quotient is below range_top, so the draw fits
    assign n_draw  = r_div[VALUE_WIDTH-1:0] + t_val'(1);
    assign n_max   = (n_draw > r_max) ? n_draw : r_max;
    assign n_min   = (n_draw < r_min) ? n_draw : r_min;
    assign n_count = r_count + t_val'(1);
    assign last    = (n_count == r_glen);

    assign out_free = !r_res_valid || i_res_ready;

    assign cfg_hit = i_cfg_we && (i_cfg_idx <= REG_GLEN);
    assign n_seed  = (i_cfg_idx == REG_SEED) ? i_cfg_data[RES_W-1:0] : r_seed;
    assign n_top   = (i_cfg_idx == REG_TOP) ? i_cfg_data[VALUE_WIDTH-1:0] : r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= RST_MULT;
            r_incr <= RST_INCR;
            r_mod  <= RST_MOD;
            r_seed <= RST_SEED;
            r_top  <= t_val'(RST_TOP);
            r_glen <= t_val'(RST_GLEN);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MULT: r_mult <= i_cfg_data[RES_W-1:0];
                REG_INCR: r_incr <= i_cfg_data[RES_W-1:0];
                REG_MOD:  r_mod  <= i_cfg_data[RES_W-1:0];
                REG_SEED: r_seed <= i_cfg_data[RES_W-1:0];
                REG_TOP:  r_top  <= i_cfg_data[VALUE_WIDTH-1:0];
                REG_GLEN: r_glen <= i_cfg_data[VALUE_WIDTH-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= 1'b0;
            r_cnt       <= '0;
            r_residue   <= RST_SEED;
            r_min       <= t_val'(RST_TOP);
            r_max       <= t_val'(1);
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready && !(r_state == ST_OUT && out_free))
                r_res_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    // a write and a request on the same edge: write first
                    if (cfg_hit) begin
                        r_residue <= n_seed;
                        r_min     <= (n_top == '0) ? t_val'(1) : n_top;
                        r_max     <= t_val'(1);
                        r_count   <= '0;
                    end
                    if (i_tick_valid && i_tick) begin
                        r_phase <= 1'b0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_cnt   <= CntW'(DivW - 1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - CntW'(1);
                    if (r_cnt == '0)
                        r_state <= ST_STEP;
                end
                ST_STEP: begin
                    if (!r_phase) begin
                        r_residue <= r_rem;
                        r_phase   <= 1'b1;
                        r_state   <= ST_MUL;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_res_valid <= 1'b1;
                        if (last) begin
                            r_min   <= eff_top;
                            r_max   <= t_val'(1);
                            r_count <= '0;
                        end else begin
                            r_min   <= n_min;
                            r_max   <= n_max;
                            r_count <= n_count;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL)
            r_prod <= t_prod'(r_residue) * t_prod'(mul_b);
        if (r_state == ST_LOAD) begin
            r_div <= t_div'(r_prod) + (r_phase ? t_div'(0) : t_div'(r_incr));
            r_rem <= '0;
        end else if (r_state == ST_DIV) begin
            r_div <= n_div;
            r_rem <= n_rem;
        end
        if (r_state == ST_OUT && out_free) begin
            r_draw      <= n_draw;
            r_spread    <= t_val'(1) + n_max - n_min;
            r_group_end <= last;
        end
    end

    assign o_tick_ready = (r_state == ST_IDLE);
    assign o_res_valid  = r_res_valid;
    assign o_draw_value = r_draw;
    assign o_spread     = r_spread;
    assign o_group_end  = r_group_end;

endmodule

`default_nettype wire

FILE: rtl/lcgrd_chk.sv
// lcgrd_chk: port-level checks for lcg_range_draw_with_spread_unit, bound to it below.
// Depends on lcgrd_pkg.
`default_nettype none

module lcgrd_chk #(
    parameter int VALUE_WIDTH = lcgrd_pkg::DEF_VALUE_WIDTH
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire [lcgrd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire [((VALUE_WIDTH > lcgrd_pkg::RES_W) ?
                  VALUE_WIDTH : lcgrd_pkg::RES_W)-1:0] i_cfg_data,
    input  wire                                    i_tick_valid,
    input  wire                                    o_tick_ready,
    input  wire                                    i_tick,
    input  wire                                    o_res_valid,
    input  wire                                    i_res_ready,
    input  wire [VALUE_WIDTH-1:0]                  o_draw_value,
    input  wire [VALUE_WIDTH-1:0]                  o_spread,
    input  wire                                    o_group_end
);
    import lcgrd_pkg::*;

    // the result register comes out of reset empty
    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_res_valid)
        else $error("result valid straight after reset");

    // a draw request keeps the unit busy for the following cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick_valid && o_tick_ready && i_tick && !i_cfg_we) |=> !o_tick_ready)
        else $error("ready high right after a draw request");

    // an empty request leaves the unit ready
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick_valid && o_tick_ready && !i_tick) |=> o_tick_ready)
        else $error("empty request made the unit busy");

    // draw and spread are never zero
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_draw_value != '0 && o_spread != '0))
        else $error("zero draw or spread");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=>
            (o_res_valid && $stable(o_draw_value) && $stable(o_spread)
             && $stable(o_group_end)))
        else $error("stalled result changed");

endmodule

bind lcg_range_draw_with_spread_unit lcgrd_chk #(.VALUE_WIDTH(VALUE_WIDTH)) u_lcgrd_chk (.*);

`default_nettype wire

FILE: test/lcg_range_draw_with_spread_unit_test.sv
`timescale 1ns / 100ps
// lcg_range_draw_with_spread_unit_test: self-checking bench for the LCG draw unit.
// Depends on lcgrd_pkg and lcg_range_draw_with_spread_unit; a directed table, then random requests.

module lcg_range_draw_with_spread_unit_test;
    import lcgrd_pkg::*;

    localparam int VW          = DEF_VALUE_WIDTH;
    localparam int CFG_W       = (VW > RES_W) ? VW : RES_W;
    localparam int DRAW_CYCLES = 133;
    localparam int SETTLE      = DRAW_CYCLES + 8;
    localparam int N_DRAWS     = 330;
    localparam int PLAN_LEN    = 40;

    // indices past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [VW-1:0] draw;
        logic [VW-1:0] spread;
        logic          group_end;
    } t_draw_result;

    typedef enum logic {ROW_WRITE, ROW_TICK} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic                 tick;
        logic                 typed;
        t_draw_result         want;
    } t_plan_row;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = REG_MULT;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 i_tick_valid = 1'b0;
    logic                 i_tick       = 1'b0;
    logic                 i_res_ready  = 1'b0;
    logic                 o_tick_ready;
    logic                 o_res_valid;
    logic [VW-1:0]        o_draw_value;
    logic [VW-1:0]        o_spread;
    logic                 o_group_end;

    lcg_range_draw_with_spread_unit #(.VALUE_WIDTH(VW)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_tick_valid (i_tick_valid),
        .o_tick_ready (o_tick_ready),
        .i_tick       (i_tick),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_draw_value (o_draw_value),
        .o_spread     (o_spread),
        .o_group_end  (o_group_end)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // draw generator state as the bench sees it
    logic [RES_W-1:0] cfg_mult, cfg_incr, cfg_mod, cfg_seed, lcg_residue;
    logic [VW-1:0]    cfg_top, cfg_glen, grp_min, grp_max, grp_count;

    t_draw_result draws_due[$];
    int           mismatches  = 0;
    int           burst_left  = 0;
    bit           need_settle = 1'b0;
    int           rx_mode     = 0;
    int           rx_left     = 0;

    t_plan_row plan [0:PLAN_LEN-1] = '{
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b1, '{16'd4, 16'd1, 1'b0}},
        '{ROW_TICK,  REG_MULT,     '0,            1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_WRITE, REG_GLEN,     31'd1,         1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b1, '{16'd4, 16'd1, 1'b1}},
        '{ROW_WRITE, REG_TOP,      31'd0,         1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b1, '{16'd1, 16'd1, 1'b1}},
        '{ROW_WRITE, REG_TOP,      31'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_WRITE, REG_MOD,      31'd1,         1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b1, '{16'd1, 16'd1, 1'b1}},
        '{ROW_WRITE, REG_MOD,      31'd0,         1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_MULT,     31'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_INCR,     31'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_SEED,     31'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_WRITE, REG_MULT,     31'd0,         1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_INCR,     31'd0,         1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_SEED,     31'd0,         1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b1, '{16'd1, 16'd1, 1'b1}},
        '{ROW_WRITE, REG_MOD,      31'd100,       1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_SEED,     31'h7FFF_FFFE, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_MULT,     31'd7,         1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_INCR,     31'd3,         1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_GLEN,     31'd3,         1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_WRITE, REG_SPARE_LO, 31'h5555_5555, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_SPARE_HI, 31'h2AAA_AAAA, 1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_WRITE, REG_GLEN,     31'd0,         1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_MULT,     '0,            1'b0, 1'b0, '0}
    };

    task automatic restart_group();
        grp_min   = (cfg_top == '0) ? VW'(1) : cfg_top;
        grp_max   = VW'(1);
        grp_count = '0;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            REG_MULT: cfg_mult = data[RES_W-1:0];
            REG_INCR: cfg_incr = data[RES_W-1:0];
            REG_MOD:  cfg_mod  = data[RES_W-1:0];
            REG_SEED: cfg_seed = data[RES_W-1:0];
            REG_TOP:  cfg_top  = data[VW-1:0];
            REG_GLEN: cfg_glen = data[VW-1:0];
            default:  return;
        endcase
        lcg_residue = cfg_seed;
        restart_group();
    endtask

    // one LCG step, range scaling and group min/max bookkeeping
    task automatic predict_draw(output t_draw_result r);
        logic [63:0]   m, n, acc, scaled;
        logic [VW-1:0] d, nxt;
        m   = (cfg_mod == '0) ? 64'h8000_0000 : 64'(cfg_mod);
        n   = (cfg_top == '0) ? 64'd1 : 64'(cfg_top);
        acc = 64'(cfg_mult) * 64'(lcg_residue) + 64'(cfg_incr);
        lcg_residue = RES_W'(acc % m);
        scaled = 64'(lcg_residue) * n / m + 64'd1;
        d = VW'(scaled);
        if (d > grp_max) grp_max = d;
        if (d < grp_min) grp_min = d;
        r.draw      = d;
        r.spread    = grp_max - grp_min + 1'b1;
        nxt         = grp_count + 1'b1;
        r.group_end = (nxt == cfg_glen);
        if (r.group_end) begin
            restart_group();
        end else begin
            grp_count = nxt;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got, want);
        mismatches++;
        $display("check: %s got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    task automatic check_result();
        t_draw_result want;
        if (draws_due.size() == 0) begin
            report_mismatch("draw with no request outstanding:", o_draw_value, 0);
            return;
        end
        want = draws_due.pop_front();
        if (o_draw_value !== want.draw) report_mismatch("draw_value", o_draw_value, want.draw);
        if (o_spread !== want.spread) report_mismatch("spread", o_spread, want.spread);
        if (o_group_end !== want.group_end)
            report_mismatch("group_end", o_group_end, want.group_end);
    endtask

    function automatic int pick_gap();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7:       return $urandom_range(1, 20);
            8:             return $urandom_range(20, 150);
            default:       return $urandom_range(100, 300);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_data(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_W-1:0] full;
        int               sel;
        full = CFG_W'($urandom);
        sel  = $urandom_range(0, 9);
        case (idx)
            REG_MULT, REG_INCR: begin
                if (sel == 0) return '0;
                if (sel == 1) return 31'h7FFF_FFFF;
                if (sel < 4) return CFG_W'($urandom_range(1, 1000));
                return full;
            end
            REG_MOD: begin
                if (sel == 0) return '0;
                if (sel == 1) return 31'd1;
                if (sel == 2) return 31'h7FFF_FFFF;
                if (sel < 5) return CFG_W'($urandom_range(2, 1000));
                return full;
            end
            REG_SEED: begin
                if (sel == 0) return '0;
                if (sel == 1) return 31'h7FFF_FFFE;
                if (sel == 2) return 31'h7FFF_FFFF;
                return full;
            end
            REG_TOP, REG_GLEN: begin
                // upper data bits are dropped by the 16-bit registers
                if (sel == 0) return '0;
                if (sel == 1) return 31'h0000_FFFF;
                if (sel == 2) return full;
                return CFG_W'($urandom_range(1, 16));
            end
            default: return full;
        endcase
    endfunction

    // config is only written with the unit idle: drained, then quiet until any request in flight is done
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_tick_valid <= 1'b0;
        while (draws_due.size() != 0) @(posedge i_clk);
        if (need_settle) begin
            repeat (SETTLE) @(posedge i_clk);
            need_settle = 1'b0;
        end
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_write(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_request(input logic t, input logic typed, input t_draw_result want);
        t_draw_result r;
        int           gap;
        if (burst_left == 0) begin
            gap = pick_gap();
            if (gap > 0) begin
                i_tick_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_tick_valid <= 1'b1;
        i_tick       <= t;
        do @(posedge i_clk); while (!o_tick_ready);
        need_settle = 1'b1;
        if (t) begin
            predict_draw(r);
            draws_due.push_back(typed ? want : r);
        end
    endtask

    // receiver: modes of free flow, random and sparse acceptance, and long stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) check_result();
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 300);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0:       i_res_ready <= 1'b1;
            1:       i_res_ready <= ($urandom_range(0, 1) == 1);
            2:       i_res_ready <= ($urandom_range(0, 9) == 0);
            default: i_res_ready <= ((rx_left / 32) % 2 == 0);
        endcase
    end

    initial begin
        int                   sent;
        int                   phase_left;
        int                   n_writes;
        logic                 t;
        logic [CFG_IDX_W-1:0] ridx;
        cfg_mult    = RST_MULT;
        cfg_incr    = RST_INCR;
        cfg_mod     = RST_MOD;
        cfg_seed    = RST_SEED;
        cfg_top     = VW'(RST_TOP);
        cfg_glen    = VW'(RST_GLEN);
        lcg_residue = cfg_seed;
        restart_group();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < PLAN_LEN; k++) begin
            if (plan[k].kind == ROW_WRITE) begin
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                send_request(plan[k].tick, plan[k].typed, plan[k].want);
            end
        end

        sent       = 0;
        phase_left = 0;
        while (sent < N_DRAWS) begin
            if (phase_left == 0) begin
                n_writes = $urandom_range(1, 4);
                repeat (n_writes) begin
                    ridx = CFG_IDX_W'($urandom_range(REG_MULT, REG_SPARE_HI));
                    write_reg(ridx, pick_data(ridx));
                end
                phase_left = $urandom_range(5, 40);
            end
            t = ($urandom_range(0, 9) != 0);
            send_request(t, 1'b0, '0);
            if (t) begin
                sent++;
                phase_left--;
            end
        end

        i_tick_valid <= 1'b0;
        while (draws_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
